// ----- design/i2cmts_pkg.sv -----
// Shared types, codes and constants of the I2C master transfer sequencer.
package i2cmts_pkg;

  // Depth clamp and status poll limit
  localparam logic [6:0] MAX_DEPTH  = 7'd64;
  localparam logic [6:0] POLL_LIMIT = 7'd100;

  // Status register bits
  localparam logic [15:0] ST_XDR  = 16'h4000;
  localparam logic [15:0] ST_RDR  = 16'h2000;
  localparam logic [15:0] ST_ROVR = 16'h0800;
  localparam logic [15:0] ST_XUDF = 16'h0400;
  localparam logic [15:0] ST_BF   = 16'h0100;
  localparam logic [15:0] ST_XRDY = 16'h0010;
  localparam logic [15:0] ST_RRDY = 16'h0008;
  localparam logic [15:0] ST_ARDY = 16'h0004;
  localparam logic [15:0] ST_NACK = 16'h0002;
  localparam logic [15:0] ST_AL   = 16'h0001;

  // Extra bits cleared on a NACK or arbitration-lost error
  localparam logic [15:0] ST_ERR_FLUSH = ST_RRDY | ST_RDR | ST_XRDY | ST_XDR | ST_ARDY | ST_BF;

  // Control register bits
  localparam logic [15:0] CON_BASE = 16'h8401;  // EN | MST | STT
  localparam logic [15:0] CON_OPHS = 16'h1000;
  localparam logic [15:0] CON_TRX  = 16'h0200;
  localparam logic [15:0] CON_XA   = 16'h0100;
  localparam logic [15:0] CON_STP  = 16'h0002;

  // Configuration register indexes
  localparam logic [1:0] REG_BUF_DEPTH  = 2'd0;
  localparam logic [1:0] REG_NO_FIFO    = 2'd1;
  localparam logic [1:0] REG_WIDE_DATA  = 2'd2;
  localparam logic [1:0] REG_HIGH_SPEED = 2'd3;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_POLL  = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    OUT_POLL      = 3'd0,
    OUT_DONE      = 3'd1,
    OUT_RESET_ERR = 3'd2,
    OUT_BUSY      = 3'd3,
    OUT_NACK_OK   = 3'd4,
    OUT_NACK_ERR  = 3'd5,
    OUT_OTHER_ERR = 3'd6
  } outcome_t;

  typedef struct packed {
    logic [6:0] buf_depth;
    logic       no_fifo;
    logic       wide_data_reg;
    logic       high_speed;
  } cfg_t;

  // Input beat payload, last member in the lowest bits
  typedef struct packed {
    logic [5:0]  tx_level;
    logic [15:0] irq_enable;
    logic [15:0] status_bits;
    logic        ignore_nack;
    logic        stop_requested;
    logic        ten_bit_addr;
    logic        read_not_write;
    logic [15:0] msg_length;
    logic [9:0]  slave_address;
  } item_t;

  // Result beat payload, last member in the lowest bits
  typedef struct packed {
    logic [15:0] remaining_length;
    outcome_t    outcome;
    logic [7:0]  bytes_consumed;
    logic [6:0]  data_writes;
    logic [6:0]  data_reads;
    logic [15:0] ack_mask;
    logic [15:0] transfer_count;
    logic [9:0]  target_address;
    logic [5:0]  threshold_field;
    logic [15:0] control_word;
  } result_t;

  typedef struct packed {
    logic [15:0] bytes_left;
    logic        receive_mode;
    logic [6:0]  fifo_threshold;
    logic [6:0]  poll_count;
    logic        nack_ignored;
    logic [15:0] saved_con;
  } state_t;

endpackage

// ----- design/i2cmts_regs.sv -----
// APB configuration registers of the transfer sequencer.
module i2cmts_regs
  import i2cmts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output cfg_t        cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;
  assign cfg     = cfg_r;

  // Write the addressed register on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{buf_depth: 7'd8, no_fifo: 1'b0, wide_data_reg: 1'b0, high_speed: 1'b0};
    end else if (wr_en) begin
      case (reg_idx)
        REG_BUF_DEPTH:  cfg_r.buf_depth     <= pwdata[6:0];
        REG_NO_FIFO:    cfg_r.no_fifo       <= pwdata[0];
        REG_WIDE_DATA:  cfg_r.wide_data_reg <= pwdata[0];
        REG_HIGH_SPEED: cfg_r.high_speed    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_BUF_DEPTH:  prdata = {25'd0, cfg_r.buf_depth};
      REG_NO_FIFO:    prdata = {31'd0, cfg_r.no_fifo};
      REG_WIDE_DATA:  prdata = {31'd0, cfg_r.wide_data_reg};
      REG_HIGH_SPEED: prdata = {31'd0, cfg_r.high_speed};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

// ----- design/i2cmts_step.sv -----
// Single-beat step logic: start setup, status decode and data-register moves.
module i2cmts_step
  import i2cmts_pkg::*;
(
  input  cfg_t    cfg,
  input  state_t  state,
  input  cmd_t    cmd,
  input  item_t   item,
  output result_t res,
  output state_t  state_nxt
);

  result_t     res_base;
  state_t      st_base;
  logic [6:0]  depth;
  logic [15:0] st_m;
  logic [6:0]  len_clamp;
  logic [6:0]  bl_clamp;
  logic [6:0]  space;
  logic [6:0]  tx_clamp;
  logic [6:0]  thr_start;
  logic [6:0]  thr_m1;
  logic [15:0] con_start;
  logic        err_any;
  logic        move_en;
  logic        move_wr;
  logic [6:0]  move_num;
  logic [15:0] bl_src;
  logic [16:0] half_sum;
  logic [15:0] half;
  logic [6:0]  ops;
  logic [7:0]  two_ops;
  logic [7:0]  moved;

  // Effective FIFO depth, clamped to 1..MAX_DEPTH
  always_comb begin
    if (cfg.no_fifo || cfg.buf_depth == 7'd0) begin
      depth = 7'd1;
    end else if (cfg.buf_depth > MAX_DEPTH) begin
      depth = MAX_DEPTH;
    end else begin
      depth = cfg.buf_depth;
    end
  end

  // Status masked by enables and by direction
  always_comb begin
    st_m = item.status_bits & item.irq_enable;
    if (state.receive_mode) begin
      st_m = st_m & ~(ST_XDR | ST_XRDY);
    end else begin
      st_m = st_m & ~(ST_RDR | ST_RRDY);
    end
  end

  // Byte counts clamped against the depth and the free transmit space
  assign len_clamp = (item.msg_length < {9'd0, depth}) ? item.msg_length[6:0] : depth;
  assign bl_clamp  = (state.bytes_left < {9'd0, depth}) ? state.bytes_left[6:0] : depth;
  assign space     = ({1'b0, item.tx_level} >= depth) ? 7'd0
                   : depth - {1'b0, item.tx_level};
  assign tx_clamp  = (state.bytes_left < {9'd0, space}) ? state.bytes_left[6:0] : space;
  assign thr_start = (cfg.no_fifo || item.msg_length == 16'd0) ? 7'd1 : len_clamp;
  assign thr_m1    = thr_start - 7'd1;
  assign err_any   = |(st_m & (ST_NACK | ST_AL | ST_ROVR | ST_XUDF));

  always_comb begin
    con_start = CON_BASE;
    if (cfg.high_speed)     con_start = con_start | CON_OPHS;
    if (item.ten_bit_addr)  con_start = con_start | CON_XA;
    if (!item.read_not_write) con_start = con_start | CON_TRX;
    if (item.stop_requested) con_start = con_start | CON_STP;
  end

  // Decode the beat: fields, state update and the data move request
  always_comb begin
    res_base = '0;
    st_base  = state;
    move_en  = 1'b0;
    move_wr  = 1'b0;
    move_num = 7'd0;
    bl_src   = state.bytes_left;
    if (cmd == CMD_START) begin
      bl_src                   = item.msg_length;
      st_base.receive_mode     = item.read_not_write;
      st_base.fifo_threshold   = thr_start;
      st_base.nack_ignored     = item.ignore_nack;
      st_base.saved_con        = con_start;
      st_base.poll_count       = 7'd0;
      res_base.control_word    = con_start;
      res_base.threshold_field = thr_m1[5:0];
      res_base.target_address  = item.slave_address;
      res_base.transfer_count  = item.msg_length;
      res_base.ack_mask        = 16'hffff;
      if (!item.read_not_write && item.msg_length != 16'd0) begin
        move_en  = 1'b1;
        move_wr  = 1'b1;
        move_num = len_clamp;
      end
    end else if (st_m == 16'd0 || state.poll_count == POLL_LIMIT) begin
      st_base.poll_count = 7'd0;
    end else begin
      st_base.poll_count = state.poll_count + 7'd1;
      if (err_any) begin
        // Error: acknowledge it, overrun/underflow beats AL beats NACK
        st_base.poll_count = 7'd0;
        res_base.ack_mask  = st_m & (ST_NACK | ST_AL);
        if ((st_m & ST_ROVR) != 16'd0) begin
          res_base.ack_mask = res_base.ack_mask | ST_ROVR;
        end else if ((st_m & ST_XUDF) != 16'd0) begin
          res_base.ack_mask = res_base.ack_mask | ST_XUDF;
        end else begin
          res_base.ack_mask = res_base.ack_mask | ST_ERR_FLUSH;
        end
        if ((st_m & (ST_ROVR | ST_XUDF)) != 16'd0) begin
          res_base.outcome = OUT_RESET_ERR;
        end else if ((st_m & ST_AL) != 16'd0) begin
          res_base.outcome = OUT_BUSY;
        end else if (state.nack_ignored) begin
          res_base.outcome = OUT_NACK_OK;
        end else begin
          res_base.outcome      = OUT_NACK_ERR;
          st_base.saved_con     = state.saved_con | CON_STP;
          res_base.control_word = state.saved_con | CON_STP;
        end
      end else if ((st_m & ST_RDR) != 16'd0) begin
        move_en           = 1'b1;
        move_num          = (bl_clamp == 7'd0) ? 7'd1 : bl_clamp;
        res_base.ack_mask = ST_RDR;
      end else if ((st_m & ST_RRDY) != 16'd0) begin
        move_en           = 1'b1;
        move_num          = (state.fifo_threshold == 7'd0) ? 7'd1 : state.fifo_threshold;
        res_base.ack_mask = ST_RRDY;
      end else if ((st_m & (ST_XDR | ST_XRDY)) != 16'd0) begin
        if (state.bytes_left != 16'd0) begin
          move_en  = 1'b1;
          move_wr  = 1'b1;
          move_num = (tx_clamp == 7'd0) ? 7'd1 : tx_clamp;
        end
        res_base.ack_mask = st_m & (ST_XDR | ST_XRDY);
      end else if ((st_m & ST_ARDY) != 16'd0) begin
        res_base.ack_mask  = ST_ARDY;
        res_base.outcome   = OUT_DONE;
        st_base.poll_count = 7'd0;
      end else if ((st_m & ST_BF) != 16'd0) begin
        res_base.ack_mask  = ST_BF;
        res_base.outcome   = OUT_DONE;
        st_base.poll_count = 7'd0;
      end
    end
  end

  // Data register accesses: one byte each, two in wide mode
  assign half_sum = {1'b0, bl_src} + 17'd1;
  assign half     = half_sum[16:1];
  always_comb begin
    if (cfg.wide_data_reg) begin
      ops = (half < {9'd0, move_num}) ? half[6:0] : move_num;
    end else begin
      ops = (bl_src < {9'd0, move_num}) ? bl_src[6:0] : move_num;
    end
  end
  assign two_ops = {ops, 1'b0};
  assign moved   = !cfg.wide_data_reg ? {1'b0, ops}
                 : (bl_src < {8'd0, two_ops}) ? bl_src[7:0] : two_ops;

  // Merge the move into the result and the byte count
  always_comb begin
    res       = res_base;
    state_nxt = st_base;
    if (move_en) begin
      res.data_reads       = move_wr ? 7'd0 : ops;
      res.data_writes      = move_wr ? ops : 7'd0;
      res.bytes_consumed   = moved;
      state_nxt.bytes_left = bl_src - {8'd0, moved};
    end else begin
      state_nxt.bytes_left = bl_src;
    end
    res.remaining_length = state_nxt.bytes_left;
  end

endmodule

// ----- design/i2c_master_transfer_sequencer_top.sv -----
// Top level of the I2C master transfer sequencer: input stage, step logic, result stage.
//
//   channel  | role            | accepted when
//   ---------+-----------------+--------------------------------------------
//   in_      | command beats   | in_tvalid & in_tready
//   out_     | result beats    | out_tvalid & out_tready
//   cfg_     | APB registers   | cfg_psel & cfg_penable & cfg_pwrite & cfg_pready
//
// One beat per cycle sustained while out_tready is high; an accepted input beat is held in
// the input register, then its result is taken into the result register.
// The step logic sits between the two registers and updates the message state
// as a beat moves into the result register, so the next beat sees it at once.
// A stalled result holds the input stage; reset is synchronous and clears
// the handshake and message state, configuration returns to its defaults.
module i2c_master_transfer_sequencer_top
  import i2cmts_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [9:0] slave_address, [25:10] msg_length, [26] read_not_write,
  // [27] ten_bit_addr, [28] stop_requested, [29] ignore_nack,
  // [45:30] status_bits, [61:46] irq_enable, [67:62] tx_level, [71:68] zero
  input  logic [71:0]  in_tdata,
  // [0] command
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [15:0] control_word, [21:16] threshold_field, [31:22] target_address,
  // [47:32] transfer_count, [63:48] ack_mask, [70:64] data_reads,
  // [77:71] data_writes, [85:78] bytes_consumed, [88:86] outcome,
  // [104:89] remaining_length, [111:105] zero
  output logic [111:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  cfg_t    cfg;
  item_t   s1_item_r;
  cmd_t    s1_cmd_r;
  logic    s1_valid_r;
  logic    s1_valid_nxt;
  logic    out_valid_r;
  logic    out_valid_nxt;
  result_t out_r;
  result_t res;
  state_t  state_r;
  state_t  state_nxt;
  logic    in_acc;
  logic    adv;

  assign cfg_pready = 1'b1;

  i2cmts_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  i2cmts_step u_step (
    .cfg       (cfg),
    .state     (state_r),
    .cmd       (s1_cmd_r),
    .item      (s1_item_r),
    .res       (res),
    .state_nxt (state_nxt)
  );

  // Handshake: advance when the result register is free or draining
  assign adv       = s1_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~s1_valid_r | ~out_valid_r | out_tready;
  assign in_acc    = in_tvalid & in_tready;

  assign s1_valid_nxt  = in_acc | (s1_valid_r & ~adv);
  assign out_valid_nxt = adv | (out_valid_r & ~out_tready);

  // Control and message state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '{bytes_left: 16'd0, receive_mode: 1'b0, fifo_threshold: 7'd1,
                       poll_count: 7'd0, nack_ignored: 1'b0, saved_con: 16'd0};
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        state_r <= state_nxt;
      end
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= item_t'(in_tdata[67:0]);
      s1_cmd_r  <= cmd_t'(in_tuser);
    end
  end

  // Hold the result beat
  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_r};

endmodule

// ----- design/i2cmts_checker.sv -----
// Port-level checks of the transfer sequencer, bound to the top level.
module i2cmts_checker
  import i2cmts_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [111:0] out_tdata,
  input logic         cfg_psel,
  input logic         cfg_pready
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // Input only backs up behind a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a stalled result");

  // The other-error code never appears
  a_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[88:86] <= OUT_NACK_ERR)
    else $error("unexpected outcome code");

  // A beat moves data in one direction only, never beyond two bytes an access
  a_one_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[70:64] == 7'd0 || out_tdata[77:71] == 7'd0)
                   && out_tdata[85:78] <= {out_tdata[70:64] | out_tdata[77:71], 1'b0})
    else $error("bad data move counts");

  // Configuration port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel |-> cfg_pready)
    else $error("cfg_pready low");

endmodule

bind i2c_master_transfer_sequencer_top i2cmts_checker u_i2cmts_checker (.*);

// ----- tb/i2c_master_transfer_sequencer_checker.sv -----
// Scoreboard for the I2C master transfer sequencer: predicts each result beat and checks it.
module i2c_master_transfer_sequencer_checker
  import i2cmts_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [71:0]  in_tdata,
  input  logic         in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [111:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  input  logic         cfg_pready,
  output int           mismatches,
  output int           results_due
);

  // Shadow copy of the configuration registers
  logic [6:0]  depth_reg;
  logic        no_fifo_reg;
  logic        wide_reg;
  logic        hs_reg;

  // Shadow copy of the message state
  logic [15:0] bytes_left;
  logic        rx_mode;
  int          thresh;
  logic [6:0]  poll_count;
  logic        nack_ok;
  logic [15:0] saved_con;

  result_t     results_q[$];
  result_t     want_beat;
  int          beat_no;

  // Print one line per mismatch and count it
  task automatic report(string what);
    $display("result beat %0d: %s", beat_no, what);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  task automatic reset_model();
    depth_reg   = 7'd8;
    no_fifo_reg = 1'b0;
    wide_reg    = 1'b0;
    hs_reg      = 1'b0;
    bytes_left  = '0;
    rx_mode     = 1'b0;
    thresh      = 1;
    poll_count  = '0;
    nack_ok     = 1'b0;
    saved_con   = '0;
  endtask

  task automatic write_register(logic [1:0] idx, logic [31:0] value);
    case (idx)
      REG_BUF_DEPTH:  depth_reg   = value[6:0];
      REG_NO_FIFO:    no_fifo_reg = value[0];
      REG_WIDE_DATA:  wide_reg    = value[0];
      REG_HIGH_SPEED: hs_reg      = value[0];
      default: ;
    endcase
  endtask

  function automatic int min_int(int a, int b);
    return (a < b) ? a : b;
  endfunction

  // Depth in use: one without FIFO, else the register clamped to 1..MAX_DEPTH
  function automatic int usable_depth();
    if (no_fifo_reg)
      return 1;
    if (depth_reg < 1)
      return 1;
    if (depth_reg > MAX_DEPTH)
      return int'(MAX_DEPTH);
    return int'(depth_reg);
  endfunction

  // Make up to num data register accesses; return the count, drain bytes_left
  function automatic int transfer_bytes(int num, output int moved);
    int ops;
    int left;
    left = int'(bytes_left);
    if (wide_reg) begin
      ops   = min_int(num, (left + 1) / 2);
      moved = min_int(left, 2 * ops);
    end else begin
      ops   = min_int(num, left);
      moved = ops;
    end
    bytes_left = 16'(left - moved);
    return ops;
  endfunction

  // Advance the message state by one beat and return the result it yields
  function automatic result_t sequence_step(cmd_t cmd, item_t it);
    result_t     r;
    logic [15:0] con;
    logic [15:0] st;
    logic [15:0] err;
    int          depth;
    int          len;
    int          n;
    int          space;
    int          moved;
    r         = '0;
    r.outcome = OUT_POLL;
    depth     = usable_depth();
    moved     = 0;
    if (cmd == CMD_START) begin
      len     = int'(it.msg_length);
      rx_mode = it.read_not_write;
      if (no_fifo_reg)
        thresh = 1;
      else
        thresh = (len < 1) ? 1 : min_int(len, depth);
      r.threshold_field = 6'(thresh - 1);
      r.target_address  = it.slave_address;
      r.transfer_count  = it.msg_length;
      r.ack_mask        = 16'hffff;
      bytes_left        = it.msg_length;
      con = CON_BASE;
      if (hs_reg)
        con |= CON_OPHS;
      if (it.ten_bit_addr)
        con |= CON_XA;
      if (!it.read_not_write)
        con |= CON_TRX;
      if (it.stop_requested)
        con |= CON_STP;
      nack_ok        = it.ignore_nack;
      saved_con      = con;
      r.control_word = con;
      poll_count     = '0;
      // Preload the transmit FIFO for a write
      if (!it.read_not_write && bytes_left != 0) begin
        r.data_writes    = 7'(transfer_bytes(min_int(len, depth), moved));
        r.bytes_consumed = 8'(moved);
      end
    end else begin
      st = it.status_bits & it.irq_enable;
      if (rx_mode)
        st &= ~(ST_XDR | ST_XRDY);
      else
        st &= ~(ST_RDR | ST_RRDY);
      if (st == 0) begin
        poll_count = '0;
      end else if (poll_count == POLL_LIMIT) begin
        poll_count = '0;
      end else begin
        poll_count = poll_count + 7'd1;
        err = st & (ST_NACK | ST_AL);
        r.ack_mask = err;
        // Overrun beats underflow; a plain NACK/AL also flushes the data, ARDY and BF flags
        if (st & ST_ROVR)
          err |= ST_ROVR;
        else if (st & ST_XUDF)
          err |= ST_XUDF;
        else if (err != 0)
          r.ack_mask |= ST_ERR_FLUSH;
        r.ack_mask |= err;
        if (err != 0) begin
          poll_count = '0;
          if (err & (ST_ROVR | ST_XUDF)) begin
            r.outcome = OUT_RESET_ERR;
          end else if (err & ST_AL) begin
            r.outcome = OUT_BUSY;
          end else if (nack_ok) begin
            r.outcome = OUT_NACK_OK;
          end else begin
            r.outcome      = OUT_NACK_ERR;
            saved_con     |= CON_STP;
            r.control_word = saved_con;
          end
        end else if (st & ST_RDR) begin
          n = min_int(int'(bytes_left), depth);
          if (n == 0)
            n = 1;
          r.data_reads     = 7'(transfer_bytes(n, moved));
          r.bytes_consumed = 8'(moved);
          r.ack_mask       = ST_RDR;
        end else if (st & ST_RRDY) begin
          r.data_reads     = 7'(transfer_bytes(thresh, moved));
          r.bytes_consumed = 8'(moved);
          r.ack_mask       = ST_RRDY;
        end else if (st & (ST_XDR | ST_XRDY)) begin
          if (bytes_left != 0) begin
            space = (int'(it.tx_level) >= depth) ? 0 : depth - int'(it.tx_level);
            n = min_int(int'(bytes_left), space);
            if (n == 0)
              n = 1;
            r.data_writes    = 7'(transfer_bytes(n, moved));
            r.bytes_consumed = 8'(moved);
          end
          r.ack_mask = st & (ST_XDR | ST_XRDY);
        end else if (st & ST_ARDY) begin
          r.ack_mask = ST_ARDY;
          r.outcome  = OUT_DONE;
          poll_count = '0;
        end else if (st & ST_BF) begin
          r.ack_mask = ST_BF;
          r.outcome  = OUT_DONE;
          poll_count = '0;
        end
      end
    end
    r.remaining_length = bytes_left;
    return r;
  endfunction

  task automatic compare_beat(logic [111:0] beat, result_t want);
    result_t got;
    got = result_t'(beat[104:0]);
    check_field("control_word", got.control_word, want.control_word);
    check_field("threshold_field", got.threshold_field, want.threshold_field);
    check_field("target_address", got.target_address, want.target_address);
    check_field("transfer_count", got.transfer_count, want.transfer_count);
    check_field("ack_mask", got.ack_mask, want.ack_mask);
    check_field("data_reads", got.data_reads, want.data_reads);
    check_field("data_writes", got.data_writes, want.data_writes);
    check_field("bytes_consumed", got.bytes_consumed, want.bytes_consumed);
    check_field("outcome", got.outcome, want.outcome);
    check_field("remaining_length", got.remaining_length, want.remaining_length);
    check_field("padding", beat[111:105], '0);
  endtask

  // Track register writes, check result beats, predict input beats
  always @(posedge clk) begin
    if (!rst_n) begin
      reset_model();
      results_q.delete();
      mismatches = 0;
      beat_no    = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)
        write_register(cfg_paddr[3:2], cfg_pwdata);
      if (out_tvalid && out_tready) begin
        if (results_q.size() == 0) begin
          report("result beat with nothing predicted");
        end else begin
          want_beat = results_q.pop_front();
          compare_beat(out_tdata, want_beat);
        end
        beat_no++;
      end
      if (in_tvalid && in_tready)
        results_q.push_back(sequence_step(cmd_t'(in_tuser), item_t'(in_tdata[67:0])));
    end
    results_due = results_q.size();
  end

endmodule

// ----- tb/i2c_master_transfer_sequencer_top_test.sv -----
// Stimulus and verdict for the I2C master transfer sequencer: messages, polls, register phases.
module i2c_master_transfer_sequencer_top_test
  import i2cmts_pkg::*;
;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 190;

  logic         clk         = 1'b0;
  logic         rst_n       = 1'b0;
  logic         in_tvalid   = 1'b0;
  logic         in_tready;
  logic [71:0]  in_tdata    = '0;
  logic         in_tuser    = 1'b0;
  logic         out_tvalid;
  logic         out_tready  = 1'b0;
  logic [111:0] out_tdata;
  logic         cfg_psel    = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite  = 1'b0;
  logic [3:0]   cfg_paddr   = '0;
  logic [31:0]  cfg_pwdata  = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  int   mismatches;
  int   results_due;
  int   items_sent   = 0;
  int   idle_cycles  = 0;
  logic steady_tail  = 1'b0;
  int   in_run_left  = 0;
  int   out_run_left = 0;
  int   out_stall_left = 0;
  int   out_pick;

  always #4 clk = ~clk;

  i2c_master_transfer_sequencer_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  i2c_master_transfer_sequencer_checker scoreboard (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_pready(cfg_pready),
    .mismatches(mismatches), .results_due(results_due)
  );

  // Stall the result side in short random bursts, with quiet stretches between
  always @(negedge clk) begin
    if (steady_tail) begin
      out_tready = 1'b1;
    end else if (out_stall_left > 0) begin
      out_tready = 1'b0;
      out_stall_left--;
    end else if (out_run_left > 0) begin
      out_tready = 1'b1;
      out_run_left--;
    end else begin
      out_pick = $urandom_range(0, 99);
      if (out_pick < 15) begin
        out_tready     = 1'b0;
        out_stall_left = $urandom_range(0, 3);
      end else begin
        out_tready = 1'b1;
        if (out_pick < 20)
          out_run_left = $urandom_range(20, 60);
      end
    end
  end

  // End the run when no beat moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("i2c_master_transfer_sequencer_top_test: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Gap before the next input beat: short bursts, quiet stretches, none at the tail
  function automatic int pick_gap();
    int r;
    if (steady_tail)
      return 0;
    if (in_run_left > 0) begin
      in_run_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 15)
      return $urandom_range(1, 4);
    if (r < 20)
      in_run_left = $urandom_range(20, 60);
    return 0;
  endfunction

  function automatic item_t random_item();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return item_t'(raw[67:0]);
  endfunction

  // Drive one beat from a falling edge and hold it until accepted
  task automatic send_beat(cmd_t cmd, item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser  = cmd;
    in_tdata  = {4'b0, it};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_start(logic rx, logic [15:0] len, logic [9:0] addr,
                            logic ten, logic stp, logic ign);
    item_t it;
    it                = random_item();
    it.read_not_write = rx;
    it.msg_length     = len;
    it.slave_address  = addr;
    it.ten_bit_addr   = ten;
    it.stop_requested = stp;
    it.ignore_nack    = ign;
    send_beat(CMD_START, it);
  endtask

  task automatic send_poll(logic [15:0] st, logic [15:0] irq, logic [5:0] lvl);
    item_t it;
    it             = random_item();
    it.status_bits = st;
    it.irq_enable  = irq;
    it.tx_level    = lvl;
    send_beat(CMD_POLL, it);
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic drain_results();
    in_tvalid = 1'b0;
    while (results_due != 0) @(negedge clk);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] value);
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = value;
    cfg_pwrite  = 1'b1;
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic set_config(int depth, logic nf, logic wide, logic hs);
    drain_results();
    repeat (4) @(negedge clk);
    apb_write(REG_BUF_DEPTH, 32'(depth));
    apb_write(REG_NO_FIFO, {31'b0, nf});
    apb_write(REG_WIDE_DATA, {31'b0, wide});
    apb_write(REG_HIGH_SPEED, {31'b0, hs});
  endtask

  function automatic logic [15:0] data_status(logic rx);
    case ($urandom_range(0, 2))
      0:       return rx ? ST_RDR : ST_XDR;
      1:       return rx ? ST_RRDY : ST_XRDY;
      default: return rx ? (ST_RDR | ST_RRDY) : (ST_XDR | ST_XRDY);
    endcase
  endfunction

  // Pick a poll status for a message in progress; flag the ones that end it
  task automatic pick_status(logic rx, output logic [15:0] st, output logic ends);
    int r;
    r    = $urandom_range(0, 99);
    ends = 1'b0;
    if (r < 45) begin
      st = data_status(rx) | ($urandom_range(0, 3) == 0 ? data_status(!rx) : 16'h0);
    end else if (r < 57) begin
      st   = ($urandom_range(0, 1) ? ST_ARDY : 16'h0) | ($urandom_range(0, 1) ? ST_BF : 16'h0);
      st   = (st == 0) ? ST_ARDY : st;
      ends = 1'b1;
    end else if (r < 67) begin
      st = ($urandom_range(0, 1) ? ST_NACK : 16'h0) | ($urandom_range(0, 1) ? ST_AL : 16'h0) |
           ($urandom_range(0, 2) == 0 ? ST_ROVR : 16'h0) |
           ($urandom_range(0, 2) == 0 ? ST_XUDF : 16'h0);
      st   = (st == 0 ? ST_NACK : st) | ($urandom_range(0, 1) ? data_status(rx) : 16'h0);
      ends = 1'b1;
    end else if (r < 75) begin
      st = 16'($urandom) & 16'h92e0 | 16'h0020;
    end else if (r < 80) begin
      st = '0;
    end else begin
      st = 16'($urandom);
    end
  endtask

  // One message: a start, then polls until it ends; a long run can walk into the poll limit
  task automatic run_message(logic long_run);
    logic        rx;
    logic        ends;
    logic [15:0] len;
    logic [15:0] st;
    logic [15:0] irq;
    int          r;
    int          n_polls;
    int          i;
    rx = 1'($urandom_range(0, 1));
    r  = $urandom_range(0, 99);
    if (r < 70)
      len = 16'($urandom_range(0, 150));
    else if (r < 90)
      len = 16'($urandom);
    else
      len = (r < 94) ? 16'd0 : (r < 97) ? 16'd1 : 16'hffff;
    send_start(rx, len, 10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    n_polls = long_run ? $urandom_range(98, 106) : $urandom_range(1, 14);
    for (i = 0; i < n_polls; i++) begin
      if (long_run) begin
        st   = data_status(rx) | (16'($urandom) & 16'h92e0);
        ends = 1'b0;
        irq  = 16'hffff;
      end else begin
        pick_status(rx, st, ends);
        irq = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'hffff;
      end
      send_poll(st, irq, ($urandom_range(0, 3) == 0) ? 6'd0 : 6'($urandom_range(0, 63)));
      if (ends)
        break;
    end
  endtask

  task automatic run_random(int count, logic force_long);
    int stop_at;
    int r;
    stop_at = items_sent + count;
    if (force_long)
      run_message(1'b1);
    while (items_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 3)
        drain_results();
      else if (r < 13)
        send_beat(cmd_t'($urandom_range(0, 1)), random_item());
      else
        run_message($urandom_range(0, 29) == 0);
    end
  endtask

  initial begin
    int phase;
    int depth;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed beats on the reset configuration
    send_poll(ST_XRDY, 16'hffff, 6'd0);
    send_start(1'b0, 16'd0, 10'd0, 1'b0, 1'b0, 1'b0);
    send_start(1'b0, 16'hffff, 10'h3ff, 1'b1, 1'b1, 1'b1);
    send_poll(ST_XRDY, 16'hffff, 6'd63);
    send_poll(ST_XDR, 16'hffff, 6'd0);
    send_poll(ST_XDR | ST_XRDY, 16'hffff, 6'd5);
    send_poll(ST_NACK, 16'hffff, 6'd0);
    send_start(1'b1, 16'd20, 10'h155, 1'b0, 1'b0, 1'b0);
    send_poll(ST_RDR, 16'hffff, 6'd0);
    send_poll(ST_RRDY, 16'hffff, 6'd0);
    send_poll(ST_XRDY | ST_RRDY, 16'hffff, 6'd0);
    send_poll(ST_NACK, 16'hffff, 6'd0);
    send_poll(ST_AL | ST_NACK, 16'hffff, 6'd0);
    send_poll(ST_ROVR | ST_AL, 16'hffff, 6'd0);
    send_poll(ST_XUDF | ST_NACK, 16'hffff, 6'd0);
    send_poll(ST_ARDY, 16'hffff, 6'd0);
    send_poll(ST_BF, 16'hffff, 6'd0);
    send_poll(16'h0000, 16'hffff, 6'd0);
    send_poll(16'hffff, 16'h0000, 6'd0);
    send_poll(16'h8000, 16'hffff, 6'd0);
    send_start(1'b1, 16'd0, 10'd0, 1'b0, 1'b0, 1'b0);
    send_poll(ST_RDR, 16'hffff, 6'd0);
    send_poll(ST_RRDY, 16'hffff, 6'd0);
    send_poll(16'hffff, 16'hffff, 6'd63);

    // Random phases, each on its own register setting; the last one runs without idling
    for (phase = 1; phase <= PHASES; phase++) begin
      case (phase)
        1: set_config(64, 1'b0, 1'b1, 1'b1);
        2: set_config(1, 1'b0, 1'b0, 1'b0);
        3: set_config(0, 1'b1, 1'b1, 1'b0);
        4: set_config(127, 1'b0, 1'b0, 1'b1);
        default: begin
          case ($urandom_range(0, 5))
            0:       depth = 8;
            1:       depth = 16;
            2:       depth = 32;
            3:       depth = 64;
            4:       depth = 1;
            default: depth = $urandom_range(0, 127);
          endcase
          set_config(depth, $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
        end
      endcase
      steady_tail = (phase == PHASES);
      run_random(PHASE_ITEMS, phase == 1);
    end

    drain_results();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && results_due == 0)
      $display("i2c_master_transfer_sequencer_top_test: clean");
    else
      $display("i2c_master_transfer_sequencer_top_test: errors");
    $finish;
  end

endmodule

// ----- sim.f -----
design/i2cmts_pkg.sv
design/i2cmts_regs.sv
design/i2cmts_step.sv
design/i2c_master_transfer_sequencer_top.sv
design/i2cmts_checker.sv
tb/i2c_master_transfer_sequencer_checker.sv
tb/i2c_master_transfer_sequencer_top_test.sv
